/* rtl/core/rtbe_pkg.sv */
// Shared types and constants for the resampling three-band equalizer.
// Depends on nothing; imported by the top level.
package rtbe_pkg;

    localparam int MAX_FRAME_SAMPLES = 1152;
    localparam int IDX_W = $clog2(MAX_FRAME_SAMPLES + 1);

    // Resampler constants: incr = floor(rate * 512 / 375) equals rate * 65536 / 48000.
    // The product rate * RATE_RECIPROCAL shifted right by RATE_SHIFT gives it
    // exactly for every 16-bit rate.
    localparam int RATE_RECIPROCAL = 45812985;
    localparam int RATE_SHIFT = 25;
    localparam int MIN_RATE = 8000;
    localparam int MAX_RUN = 7;

    // Configuration register indexes.
    localparam logic [2:0] REG_LOW_COEF  = 3'd0;
    localparam logic [2:0] REG_HIGH_COEF = 3'd1;
    localparam logic [2:0] REG_LOW_GAIN  = 3'd2;
    localparam logic [2:0] REG_MID_GAIN  = 3'd3;
    localparam logic [2:0] REG_HIGH_GAIN = 3'd4;

    typedef struct packed {
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic               is_stereo;
        logic [15:0]        source_rate;
        logic               first_in_frame;
    } in_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               last_of_run;
    } out_t;

endpackage

/* rtl/core/resampling_three_band_equalizer.sv */
// Top level of the resampling three-band equalizer: resampler sequencer,
// shared multiplier datapath and output register. Depends on rtbe_pkg.
//
// Usage: one Q28 sample, stereo or mono, enters per request on the input
// channel (accepted when valid is high and stall is low). Each request
// yields zero to seven 48 kHz results on the output channel; last_of_run
// marks the final one of a request. Register writes go through the cfg
// channel, which is always ready; the user must make them only while the
// block is idle, as the block itself does not enforce it.
// Sequencing: a request is set up at acceptance, where the position
// increment comes from a constant reciprocal multiply, and then checked.
// Each result is computed for both channels in stereo and one in mono by a
// single 34x17 multiplier that serves every pole update and band gain, each
// in a multiply state and an accumulate state. Input stall stays high until
// the request is fully done. A result sits in the output register; while
// the receiver stalls, the sequencer waits before loading the next result.
// Reset clears the filter state, delay line, resample position and frame
// index, and loads the register defaults.
module resampling_three_band_equalizer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  rtbe_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output rtbe_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);
    import rtbe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic [3:0] STEP_LOW_BAND  = 4'd8;
    localparam logic [3:0] STEP_HIGH_BAND = 4'd9;
    localparam logic [3:0] STEP_MID_BAND  = 4'd10;

    logic [2:0]  state_reg;
    logic [15:0] low_coef_reg, high_coef_reg, low_gain_reg, mid_gain_reg, high_gain_reg;

    logic signed [31:0] pole_reg [16];
    logic signed [15:0] dl_reg [6];
    logic [31:0]        pos_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic signed [15:0] samp_reg [2];
    logic               stereo_reg;
    logic [16:0]        incr_reg;
    logic [2:0]         count_reg;
    logic               ch_reg;
    logic [3:0]         step_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] prev_reg;
    logic signed [32:0] lval_reg, hval_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] lres_reg, rres_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    // Clip a Q28 sample to 16 bits.
    function automatic logic signed [15:0] clip_q28(input logic signed [31:0] v);
        logic signed [31:0] sh;
        sh = v >>> 13;
        if (v >= 32'sh1000_0000)
            return 16'sd32767;
        else if (v <= -32'sh1000_0000)
            return -16'sd32767;
        else
            return sh[15:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Datapath operand selection for the shared multiplier.
    logic [3:0]         rd_addr;
    logic signed [31:0] pole_rd;
    logic signed [31:0] d3;
    logic signed [31:0] x_in;
    logic signed [33:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mid_val;

    always_comb
    begin
        rd_addr = {ch_reg, 3'd0};
        if (step_reg < STEP_LOW_BAND)
            rd_addr = {ch_reg, step_reg[2:0]};
        else if (step_reg == STEP_LOW_BAND)
            rd_addr = {ch_reg, 3'd3};
        else
            rd_addr = {ch_reg, 3'd7};
    end

    assign pole_rd = pole_reg[rd_addr];
    assign d3      = {dl_reg[ch_reg ? 3'd5 : 3'd2], 16'd0};
    assign x_in    = {samp_reg[ch_reg], 16'd0};
    assign mid_val = {{2{d3[31]}}, d3} - ({hval_reg[32], hval_reg} + {lval_reg[32], lval_reg});

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (step_reg < STEP_LOW_BAND)
        begin
            if (step_reg[1:0] == 2'd0)
                mul_a = {{2{x_in[31]}}, x_in} - {{2{pole_rd[31]}}, pole_rd};
            else
                mul_a = {{2{prev_reg[31]}}, prev_reg} - {{2{pole_rd[31]}}, pole_rd};
            mul_b = {1'b0, step_reg[2] ? high_coef_reg : low_coef_reg};
        end
        else if (step_reg == STEP_LOW_BAND)
        begin
            mul_a = {{2{pole_rd[31]}}, pole_rd};
            mul_b = {1'b0, low_gain_reg};
        end
        else if (step_reg == STEP_HIGH_BAND)
        begin
            mul_a = {{2{d3[31]}}, d3} - {{2{pole_rd[31]}}, pole_rd};
            mul_b = {1'b0, high_gain_reg};
        end
        else
        begin
            mul_a = mid_val;
            mul_b = {1'b0, mid_gain_reg};
        end
    end

    // Pole update: p + floor(prod / 2^15), saturated to 32 bits.
    logic signed [51:0] pole_sum;
    logic signed [31:0] pole_sat;
    assign pole_sum = {{20{pole_rd[31]}}, pole_rd} + {prod_reg[50], (prod_reg >>> 15)};

    always_comb
    begin
        if (pole_sum > 52'sh0_0000_7FFF_FFFF)
            pole_sat = 32'sh7FFF_FFFF;
        else if (pole_sum < -52'sh0_0000_8000_0000)
            pole_sat = -32'sh8000_0000;
        else
            pole_sat = pole_sum[31:0];
    end

    // Final scaling: truncate toward zero by 2^16, then saturate to 16 bits.
    logic [39:0]        acc_mag;
    logic signed [39:0] acc_q;
    logic signed [15:0] res_sat;
    assign acc_mag = acc_reg[39] ? 40'(-acc_reg) : acc_reg;
    assign acc_q   = acc_reg[39] ? -$signed(acc_mag >> 16) : $signed(acc_mag >> 16);

    always_comb
    begin
        if (acc_q > 40'sd32767)
            res_sat = 16'sh7FFF;
        else if (acc_q < -40'sd32768)
            res_sat = -16'sh8000;
        else
            res_sat = acc_q[15:0];
    end

    // Resampler control values.
    logic [15:0] rate_clamped;
    logic [41:0] incr_prod;
    logic [31:0] next_pos;
    logic        run_more;
    logic        emit_load;
    assign rate_clamped = (in_data.source_rate < 16'(MIN_RATE)) ? 16'(MIN_RATE)
                                                               : in_data.source_rate;
    assign incr_prod    = {26'd0, rate_clamped} * 42'(RATE_RECIPROCAL);
    assign next_pos     = pos_reg + {15'd0, incr_reg};
    assign run_more     = (next_pos[31:16] <= 16'(idx_reg)) && (count_reg < 3'(MAX_RUN - 1));
    assign emit_load    = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_coef_reg  <= 16'd3773;
            high_coef_reg <= 16'd21066;
            low_gain_reg  <= 16'd4096;
            mid_gain_reg  <= 16'd4096;
            high_gain_reg <= 16'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOW_COEF:  low_coef_reg  <= cfg_data;
                REG_HIGH_COEF: high_coef_reg <= cfg_data;
                REG_LOW_GAIN:  low_gain_reg  <= cfg_data;
                REG_MID_GAIN:  mid_gain_reg  <= cfg_data;
                REG_HIGH_GAIN: high_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            samp_reg[0] <= clip_q28(in_data.left_sample);
            samp_reg[1] <= clip_q28(in_data.right_sample);
            stereo_reg  <= in_data.is_stereo;
            incr_reg    <= incr_prod[RATE_SHIFT +: 17];
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= mul_a * mul_b;
            if (step_reg == STEP_LOW_BAND)
                lval_reg <= {pole_rd[31], pole_rd};
            if (step_reg == STEP_HIGH_BAND)
                hval_reg <= mul_a[32:0];
        end
        if (state_reg == S_ACC)
        begin
            if (step_reg < STEP_LOW_BAND)
                prev_reg <= pole_sat;
            else
                acc_reg <= acc_reg + 40'(prod_reg >>> 12);
        end
        if (state_reg == S_CHECK || (state_reg == S_FIN && !ch_reg))
            acc_reg <= '0;
        if (state_reg == S_FIN)
        begin
            if (!ch_reg)
            begin
                lres_reg <= res_sat;
                rres_reg <= res_sat;
            end
            else
                rres_reg <= res_sat;
        end
    end

    // Sequencer, filter state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            idx_reg       <= '0;
            count_reg     <= '0;
            ch_reg        <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < 16; i++)
                pole_reg[i] <= '0;
            for (int i = 0; i < 6; i++)
                dl_reg[i] <= '0;
        end
        else
        begin
            // Output valid is set when a result loads and cleared when it is taken.
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.first_in_frame)
                        begin
                            pos_reg <= '0;
                            idx_reg <= '0;
                        end
                        count_reg <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    ch_reg   <= 1'b0;
                    step_reg <= '0;
                    if (idx_reg >= IDX_W'(MAX_FRAME_SAMPLES))
                    begin
                        idx_reg   <= IDX_W'(MAX_FRAME_SAMPLES);
                        state_reg <= S_IDLE;
                    end
                    else if (pos_reg[31:16] <= 16'(idx_reg) && count_reg < 3'(MAX_RUN))
                        state_reg <= S_MUL;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_MUL:
                    state_reg <= S_ACC;
                S_ACC:
                begin
                    if (step_reg < STEP_LOW_BAND)
                        pole_reg[rd_addr] <= pole_sat;
                    if (step_reg == STEP_MID_BAND)
                        state_reg <= S_FIN;
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_FIN:
                begin
                    // Shift this channel's delay line.
                    if (!ch_reg)
                    begin
                        dl_reg[2] <= dl_reg[1];
                        dl_reg[1] <= dl_reg[0];
                        dl_reg[0] <= samp_reg[0];
                    end
                    else
                    begin
                        dl_reg[5] <= dl_reg[4];
                        dl_reg[4] <= dl_reg[3];
                        dl_reg[3] <= samp_reg[1];
                    end
                    step_reg <= '0;
                    if (!ch_reg && stereo_reg)
                    begin
                        ch_reg    <= 1'b1;
                        state_reg <= S_MUL;
                    end
                    else
                        state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_reg.left_out    <= lres_reg;
                        out_reg.right_out   <= rres_reg;
                        out_reg.last_of_run <= !run_more;
                        pos_reg             <= next_pos;
                        count_reg           <= count_reg + 3'd1;
                        state_reg           <= S_CHECK;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The frame index saturates at the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(MAX_FRAME_SAMPLES))
        else $error("frame index beyond limit");

    // No request ever produces more than the maximum run of results.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(MAX_RUN))
        else $error("result run too long");

    // A new result only appears after the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EMIT))
        else $error("result loaded outside emit");
`endif

endmodule
